[rtl/pvu_pkg.sv]
package pvu_pkg;

  localparam int RANK_W = 32;
  localparam int DEG_W  = 24;
  localparam int DAMP_W = 16;
  localparam int SUM_W  = 48;
  localparam int ID_W   = 32;
  localparam int TAG_W  = 8;
  localparam int PROD_W = SUM_W + DAMP_W;
  localparam int HALF_W = SUM_W / 2;

  localparam logic [DAMP_W-1:0] DAMPING_RST   = 16'd55706;
  localparam logic [RANK_W-1:0] BASE_RANK_RST = 32'd9830;

  localparam logic REG_DAMPING   = 1'b0;
  localparam logic REG_BASE_RANK = 1'b1;

  typedef struct packed {
    logic              do_div;
    logic              is_last;
    logic [RANK_W-1:0] rank;
    logic [DEG_W-1:0]  degree;
    logic [ID_W-1:0]   vertex_id;
    logic [TAG_W-1:0]  vertex_tag;
  } pvu_item_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DIV    = 6'b000010,
    S_ACC    = 6'b000100,
    S_MUL_LO = 6'b001000,
    S_MUL_HI = 6'b010000,
    S_FIN    = 6'b100000
  } pvu_state_t;

endpackage

[rtl/pvu_front.sv]
module pvu_front #(
  parameter int DEGREE_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_has_message,
  input  logic                             in_is_last,
  input  logic [pvu_pkg::RANK_W-1:0]       in_msg_rank,
  input  logic [pvu_pkg::DEG_W-1:0]        in_msg_degree,
  input  logic [pvu_pkg::ID_W-1:0]         in_vertex_id,
  input  logic [pvu_pkg::TAG_W-1:0]        in_vertex_tag,
  output logic                             q_valid,
  output pvu_pkg::pvu_item_t               q_item,
  input  logic                             q_pop
);

  localparam int DegUse = (DEGREE_BITS < pvu_pkg::DEG_W) ? DEGREE_BITS : pvu_pkg::DEG_W;
  localparam logic [pvu_pkg::DEG_W-1:0] DegMask =
    pvu_pkg::DEG_W'((33'd1 << DegUse) - 33'd1);
  localparam int QDepth = 2;
  localparam int PtrW   = $clog2(QDepth);

  pvu_pkg::pvu_item_t  mem_r [QDepth];
  pvu_pkg::pvu_item_t  item;
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PtrW:0]       cnt_r, cnt_nxt;
  logic [pvu_pkg::DEG_W-1:0] degree;
  logic                push;
  logic                pop;

  assign degree = in_msg_degree & DegMask;

  always_comb begin
    item.do_div     = in_has_message && (degree != '0);
    item.is_last    = in_is_last;
    item.rank       = in_msg_rank;
    item.degree     = degree;
    item.vertex_id  = in_vertex_id;
    item.vertex_tag = in_vertex_tag;
  end

  assign in_ready = (cnt_r != (PtrW+1)'(QDepth));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? PtrW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PtrW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

[rtl/pvu_back.sv]
module pvu_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [pvu_pkg::DAMP_W-1:0]       damping,
  input  logic [pvu_pkg::RANK_W-1:0]       base_rank,
  input  logic                             q_valid,
  input  pvu_pkg::pvu_item_t               q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pvu_pkg::ID_W-1:0]         out_vertex_id,
  output logic [pvu_pkg::RANK_W-1:0]       out_new_rank,
  output logic [pvu_pkg::TAG_W-1:0]        out_vertex_tag,
  output logic                             out_saturated
);

  localparam int RankW = pvu_pkg::RANK_W;
  localparam int DegW  = pvu_pkg::DEG_W;
  localparam int SumW  = pvu_pkg::SUM_W;
  localparam int HalfW = pvu_pkg::HALF_W;
  localparam int ProdW = pvu_pkg::PROD_W;
  localparam int PartW = HalfW + pvu_pkg::DAMP_W;
  localparam int CntW  = $clog2(RankW);

  pvu_pkg::pvu_state_t state_r, state_nxt;
  pvu_pkg::pvu_item_t  item_r, item_nxt;
  logic [RankW-1:0]    quo_r, quo_nxt;
  logic [DegW-1:0]     rem_r, rem_nxt;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic [SumW-1:0]     sum_r, sum_nxt;
  logic [PartW-1:0]    plo_r, plo_nxt;
  logic [ProdW-1:0]    prod_r, prod_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [pvu_pkg::ID_W-1:0]  out_id_r, out_id_nxt;
  logic [RankW-1:0]          out_rank_r, out_rank_nxt;
  logic [pvu_pkg::TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic                      out_sat_r, out_sat_nxt;

  logic [DegW:0]       trial;
  logic                fits;
  logic [SumW:0]       acc;
  logic [PartW-1:0]    phi;
  logic [SumW:0]       total;

  always_comb begin
    trial = {rem_r, quo_r[RankW-1]};
    fits  = (trial >= {1'b0, item_r.degree});
    acc   = {1'b0, sum_r} + (SumW+1)'(quo_r);
    phi   = PartW'(sum_r[SumW-1:HalfW]) * PartW'(damping);
    total = (SumW+1)'(prod_r[ProdW-1:pvu_pkg::DAMP_W]) + (SumW+1)'(base_rank);
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    plo_nxt       = plo_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_rank_nxt  = out_rank_r;
    out_tag_nxt   = out_tag_r;
    out_sat_nxt   = out_sat_r;
    q_pop         = 1'b0;
    case (state_r)
      pvu_pkg::S_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          item_nxt = q_item;
          quo_nxt  = q_item.rank;
          rem_nxt  = '0;
          cnt_nxt  = '1;
          if (q_item.do_div) begin
            state_nxt = pvu_pkg::S_DIV;
          end else if (q_item.is_last) begin
            state_nxt = pvu_pkg::S_MUL_LO;
          end
        end
      end
      pvu_pkg::S_DIV: begin
        rem_nxt = fits ? DegW'(trial - {1'b0, item_r.degree}) : trial[DegW-1:0];
        quo_nxt = {quo_r[RankW-2:0], fits};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = pvu_pkg::S_ACC;
        end
      end
      pvu_pkg::S_ACC: begin
        sum_nxt   = acc[SumW] ? '1 : acc[SumW-1:0];
        state_nxt = item_r.is_last ? pvu_pkg::S_MUL_LO : pvu_pkg::S_IDLE;
      end
      pvu_pkg::S_MUL_LO: begin
        plo_nxt   = PartW'(sum_r[HalfW-1:0]) * PartW'(damping);
        state_nxt = pvu_pkg::S_MUL_HI;
      end
      pvu_pkg::S_MUL_HI: begin
        prod_nxt  = {phi, HalfW'(0)} + ProdW'(plo_r);
        state_nxt = pvu_pkg::S_FIN;
      end
      pvu_pkg::S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = item_r.vertex_id;
          out_tag_nxt   = item_r.vertex_tag;
          out_sat_nxt   = (total[SumW:RankW] != '0);
          out_rank_nxt  = out_sat_nxt ? '1 : total[RankW-1:0];
          sum_nxt       = '0;
          state_nxt     = pvu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pvu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pvu_pkg::S_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    plo_r      <= plo_nxt;
    prod_r     <= prod_nxt;
    out_id_r   <= out_id_nxt;
    out_rank_r <= out_rank_nxt;
    out_tag_r  <= out_tag_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_vertex_id  = out_id_r;
  assign out_new_rank   = out_rank_r;
  assign out_vertex_tag = out_tag_r;
  assign out_saturated  = out_sat_r;

endmodule

[rtl/pagerank_vertex_update_unit.sv]
// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_ready    one rank message or empty marker
// out_      output     out_valid/out_ready  updated rank of one vertex
// cfg_      input      cfg_we               damping or base_rank register write
//
// A message with nonzero degree passes through the back end in order: the
// queue pop, the radix-2 restoring divider, and the accumulate. An empty marker
// only pops the queue. The last word adds two multiply steps and the final add.
// A two-word queue lets input words land while the divider runs.
// Reset is synchronous, active low, and clears the accumulator, the queue and
// the output register.
// A result waiting at the output stalls the back end only at the final step.
module pagerank_vertex_update_unit #(
  parameter int DEGREE_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [pvu_pkg::RANK_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_has_message,
  input  logic                             in_is_last,
  input  logic [pvu_pkg::RANK_W-1:0]       in_msg_rank,
  input  logic [pvu_pkg::DEG_W-1:0]        in_msg_degree,
  input  logic [pvu_pkg::ID_W-1:0]         in_vertex_id,
  input  logic [pvu_pkg::TAG_W-1:0]        in_vertex_tag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pvu_pkg::ID_W-1:0]         out_vertex_id,
  output logic [pvu_pkg::RANK_W-1:0]       out_new_rank,
  output logic [pvu_pkg::TAG_W-1:0]        out_vertex_tag,
  output logic                             out_saturated
);

  logic [pvu_pkg::DAMP_W-1:0] damping_r;
  logic [pvu_pkg::RANK_W-1:0] base_rank_r;
  logic                       q_valid;
  logic                       q_pop;
  pvu_pkg::pvu_item_t         q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r   <= pvu_pkg::DAMPING_RST;
      base_rank_r <= pvu_pkg::BASE_RANK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pvu_pkg::REG_DAMPING:   damping_r   <= cfg_wdata[pvu_pkg::DAMP_W-1:0];
        pvu_pkg::REG_BASE_RANK: base_rank_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pvu_front #(
    .DEGREE_BITS(DEGREE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_has_message(in_has_message),
    .in_is_last    (in_is_last),
    .in_msg_rank   (in_msg_rank),
    .in_msg_degree (in_msg_degree),
    .in_vertex_id  (in_vertex_id),
    .in_vertex_tag (in_vertex_tag),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  pvu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .damping       (damping_r),
    .base_rank     (base_rank_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_vertex_id (out_vertex_id),
    .out_new_rank  (out_new_rank),
    .out_vertex_tag(out_vertex_tag),
    .out_saturated (out_saturated)
  );

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("input stalled with empty queue");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_new_rank == '1)
    else $error("saturated result not clipped");
`endif

endmodule
